FILE: hdl/rbof_pkg.sv
// Shared types and codes for the overwriting ring buffer FIFO.
package rbof_pkg;

  // Field widths of the stream words
  localparam int ACT_W  = 3;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int ST_W   = 2;

  // Packed stream widths (padded to whole bytes)
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 8;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PUT      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUT_ROOM = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GET      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PEEK     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COPY_RUN = 3'd4;
  localparam logic [ACT_W-1:0] ACT_GET_RUN  = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_OVR     = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_REFUSED = 2'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;     // latch the accepted word
    logic finish;      // complete an item that needs no memory read
    logic start_read;  // issue first read, update pointers on removal
    logic emit;        // push read element into output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic needs_read;  // captured item delivers elements
    logic out_free;    // output register can take a word
    logic run_more;    // more elements follow the one being emitted
  } sts_t;

endpackage

FILE: hdl/ring_buffer_overwrite_fifo.sv
// Overwriting ring buffer FIFO: top level with stream ports and checks.
//
// Usage: one command word enters on the s_axis channel (action in tuser);
// each command gives one or more result words on m_axis, the final one
// marked by tlast. Puts write; when full, put overwrites the oldest element
// and put-room is refused. Copy and get runs stream up to count oldest elements.
// cfg_we/cfg_wdata set the used ring size (1..DEPTH) and empty the ring.
// Timing: a command is accepted, evaluated in the next cycle and, for an
// item with no element (puts, empty gets, empty runs), its result is
// registered at the end of that cycle when the output register is free.
// Get, peek and runs issue their first read then and emit one element per
// cycle while the output register is free, from the registered memory port.
// The next command is taken while the last result still sits in the
// output register. Reset empties the ring and sets the size to DEPTH; no
// memory clearing is done. When the receiver holds m_axis_tready low, the
// output register holds its word and the run pauses until it is taken.
module ring_buffer_overwrite_fifo import rbof_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // Size register
  input  logic                   cfg_we,
  input  logic [CNT_W-1:0]       cfg_wdata,
  // Command words
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // element_data[31:0], count[38:32]
  input  logic [ACT_W-1:0]       s_axis_tuser,   // action[2:0]
  // Result words
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_data[31:0], count_done[38:32],
                                                 // fill_after[45:39]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // data_valid[0], status[2:1]
  output logic                   m_axis_tlast
);

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] out_data;
  logic              out_dvalid;
  logic [ST_W-1:0]   out_status;
  logic [CNT_W-1:0]  out_done;
  logic [CNT_W-1:0]  out_fill;

  rbof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbof_dp #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_action  (s_axis_tuser),
    .in_elem    (s_axis_tdata[DATA_W-1:0]),
    .in_count   (s_axis_tdata[DATA_W+CNT_W-1:DATA_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_data),
    .out_dvalid (out_dvalid),
    .out_status (out_status),
    .out_last   (m_axis_tlast),
    .out_done   (out_done),
    .out_fill   (out_fill)
  );

  // Output packing
  assign m_axis_tdata = {(OUT_TDATA_W-DATA_W-2*CNT_W)'(0), out_fill, out_done, out_data};
  assign m_axis_tuser = {(OUT_TUSER_W-ST_W-1)'(0), out_status, out_dvalid};

`ifndef SYNTHESIS
  // One command at a time: no accept right after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command accepted while previous one in progress");

  // Words without an element end the command's output
  a_noelem_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_dvalid) |-> (m_axis_tlast && out_data == '0 && out_done == '0))
    else $error("non-element result not final or not zeroed");

  // Run words carry elements with ok status
  a_run_words: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_done != '0) |-> (out_dvalid && out_status == ST_OK))
    else $error("run word without element or with bad status");

  // Elements are never emitted while the output register is blocked and holds data
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten before it was taken");
`endif

endmodule

FILE: hdl/rbof_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbof_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/rbof_ctrl.sv
// Sequencing state machine for the overwriting ring buffer FIFO.
module rbof_ctrl import rbof_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.needs_read) begin
          cmd.start_read = 1'b1;
          state_next     = S_READ;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (!sts.run_more) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/rbof_dp.sv
// Datapath: pointers, fill level, element store and output register.
module rbof_dp import rbof_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [DATA_W-1:0] in_elem,
  input  logic [CNT_W-1:0]  in_count,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data,
  output logic              out_dvalid,
  output logic [ST_W-1:0]   out_status,
  output logic              out_last,
  output logic [CNT_W-1:0]  out_done,
  output logic [CNT_W-1:0]  out_fill
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (ELEM_WIDTH < DATA_W) ? ELEM_WIDTH : DATA_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Captured word
  logic [ACT_W-1:0]  act;
  logic [DATA_W-1:0] elem;
  logic [CNT_W-1:0]  cnt;

  // Ring state
  logic [CNT_W-1:0] size;
  logic [AW-1:0]    rd;
  logic [CNT_W-1:0] fill;

  // Run sequencing
  logic [AW-1:0]    run_idx;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] done_val;

  // Decode and arithmetic
  logic             is_put, is_single, is_run, removes;
  logic             full, empty;
  logic [CNT_W-1:0] run_n;
  logic [CNT_W:0]   wr_sum, adv_sum, size_x;
  logic [AW-1:0]    wr_addr, adv_idx;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [DATA_W-1:0] rd_word;
  logic [ST_W-1:0]  fin_status;
  logic [AW-1:0]    fin_rd;
  logic [CNT_W-1:0] fin_fill;
  logic [CNT_W-1:0] size_cfg;

  // Index step with wrap at the used size
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x,
                                             input logic [CNT_W-1:0] sz);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(x) + 1'b1;
    return (nx == sz) ? '0 : AW'(nx);
  endfunction

  // Action decode
  always_comb begin
    is_put    = (act == ACT_PUT) || (act == ACT_PUT_ROOM);
    is_single = (act == ACT_GET) || (act == ACT_PEEK);
    is_run    = (act == ACT_COPY_RUN) || (act == ACT_GET_RUN);
    removes   = (act == ACT_GET) || (act == ACT_GET_RUN);
    full      = fill >= size;
    empty     = fill == '0;
    run_n     = (cnt > fill) ? fill : cnt;
  end

  // Write slot and run advance, sums stay below twice the size
  always_comb begin
    size_x  = {1'b0, size};
    wr_sum  = (CNT_W+1)'(rd) + {1'b0, fill};
    adv_sum = (CNT_W+1)'(rd) + {1'b0, run_n};
    wr_addr = (wr_sum >= size_x) ? AW'(wr_sum - size_x) : AW'(wr_sum);
    adv_idx = (adv_sum >= size_x) ? AW'(adv_sum - size_x) : AW'(adv_sum);
  end

  // Saturate written size to 1..DEPTH
  always_comb begin
    if (cfg_wdata == '0) begin
      size_cfg = CNT_W'(1);
    end else if (cfg_wdata > DEPTH_C) begin
      size_cfg = DEPTH_C;
    end else begin
      size_cfg = cfg_wdata;
    end
  end

  // Result of an item that reads no element
  always_comb begin
    ram_we     = 1'b0;
    fin_status = ST_OK;
    fin_rd     = rd;
    fin_fill   = fill;
    if (is_put) begin
      if (full && (act == ACT_PUT_ROOM)) begin
        fin_status = ST_REFUSED;
      end else begin
        ram_we = cmd.finish;
        if (full) begin
          fin_rd     = wrap_inc(rd, size);
          fin_status = ST_OVR;
        end else begin
          fin_fill = fill + 1'b1;
        end
      end
    end else if (is_single || is_run) begin
      fin_status = empty ? ST_EMPTY : ST_OK;
    end
  end

  // Status to controller
  always_comb begin
    sts.needs_read = (is_single && !empty) || (is_run && (run_n != '0));
    sts.out_free   = !out_valid || out_ready;
    sts.run_more   = remain != CNT_W'(1);
  end

  // Memory access
  always_comb begin
    ram_re    = cmd.start_read || (cmd.emit && sts.run_more);
    ram_raddr = cmd.start_read ? rd : run_idx;
    ram_wdata = '0;
    ram_wdata[CW-1:0] = elem[CW-1:0];
    rd_word   = '0;
    rd_word[CW-1:0] = ram_rdata[CW-1:0];
  end

  rbof_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Ring control state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= DEPTH_C;
      rd        <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        size <= size_cfg;
        rd   <= '0;
        fill <= '0;
      end else if (cmd.finish) begin
        rd   <= fin_rd;
        fill <= fin_fill;
      end else if (cmd.start_read && removes) begin
        if (is_single) begin
          rd   <= wrap_inc(rd, size);
          fill <= fill - 1'b1;
        end else begin
          rd   <= adv_idx;
          fill <= fill - run_n;
        end
      end
      if (cmd.finish || cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Captured word, run counters and output payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act  <= in_action;
      elem <= in_elem;
      cnt  <= in_count;
    end
    if (cmd.start_read) begin
      run_idx  <= wrap_inc(rd, size);
      remain   <= is_run ? run_n : CNT_W'(1);
      done_val <= is_run ? run_n : '0;
    end
    if (cmd.emit) begin
      remain <= remain - 1'b1;
      if (sts.run_more) begin
        run_idx <= wrap_inc(run_idx, size);
      end
      out_data   <= rd_word;
      out_dvalid <= 1'b1;
      out_status <= ST_OK;
      out_last   <= !sts.run_more;
      out_done   <= done_val;
      out_fill   <= fill;
    end
    if (cmd.finish) begin
      out_data   <= '0;
      out_dvalid <= 1'b0;
      out_status <= fin_status;
      out_last   <= 1'b1;
      out_done   <= '0;
      out_fill   <= fin_fill;
    end
  end

endmodule
